[rtl/core/usemi_pkg.sv]
package usemi_pkg;

    localparam int COORD_W     = 8;
    localparam int RADIUS_W    = 7;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 9;   // signed, goes one below zero at a radius of zero
    localparam int TERM_W      = 12;  // signed decision term, no overflow at any radius
    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_STEPS   = 63;

    localparam int IN_DATA_W   = 24;  // 8 + 8 + 7 + 1, already whole bytes
    localparam int OUT_DATA_W  = 72;  // 8 * 8 + 1, padded to 9 bytes

    localparam logic signed [TERM_W-1:0] STEP_INC_INSIDE  = TERM_W'(3);
    localparam logic signed [TERM_W-1:0] STEP_INC_OUTSIDE = TERM_W'(5);
    localparam logic signed [TERM_W-1:0] TERM_START       = TERM_W'(1);

    // one queued draw request, already set up for the step engine
    typedef struct packed {
        logic [COORD_W-1:0]             center_x;
        logic [COORD_W-1:0]             center_y;
        logic signed [ROW_W-1:0]        row_start;
        logic signed [TERM_W-1:0]       term_start;
        logic                           color;
    } req_t;

endpackage

[rtl/core/upper_semicircle_rasterizer.sv]
// channel   | dir | handshake               | payload
// ----------+-----+-------------------------+---------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready    | draw request: center, radius, pen color
// m_axis    | out | m_axis_tvalid/tready    | one step: four mirrored pixels, color; tlast
//
// a request of radius r gives n results, n about r / sqrt(2) + 1, never more than 63
// the step engine emits one result per cycle while the output is not stalled
// between runs the engine is idle while it takes the next request from the queue
// reset clears the queue and the engine; a stalled output holds the engine in place
// the request queue keeps taking items while a run is under way or stalled, until it is full
module upper_semicircle_rasterizer #(
    parameter int QueueDepth = usemi_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // center_x[7:0], center_y[15:8], radius[22:16], pen_color[23]
    input  logic [usemi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // east_x[7:0], east_y[15:8], upper_right_x[23:16], upper_right_y[31:24],
    // upper_left_x[39:32], upper_left_y[47:40], west_x[55:48], west_y[63:56],
    // pixel_value[64], zero pad[71:65]
    output logic [usemi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_step
    output logic                             m_axis_tlast
);
    import usemi_pkg::*;

    logic req_valid;
    logic req_ready;
    req_t req;

    // front: unpacks each item, sets up the first step and queues it
    usemi_front #(
        .QueueDepth(QueueDepth)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req)
    );

    // back: midpoint step engine with a registered output stage
    usemi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

[rtl/core/usemi_front.sv]
module usemi_front #(
    parameter int QueueDepth = usemi_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [usemi_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                           req_valid,
    input  logic                           req_ready,
    output usemi_pkg::req_t                req
);
    import usemi_pkg::*;

    localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CNT_W = $clog2(QueueDepth + 1);

    req_t             queue_mem [QueueDepth];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    req_t             new_req;
    logic [RADIUS_W-1:0] radius;

    // unpack the item and set up the first step
    always_comb
    begin
        radius              = s_axis_tdata[22:16];
        new_req.center_x    = s_axis_tdata[7:0];
        new_req.center_y    = s_axis_tdata[15:8];
        new_req.color       = s_axis_tdata[23];
        new_req.row_start   = signed'(ROW_W'(radius));
        new_req.term_start  = TERM_START - signed'(TERM_W'(radius));
    end

    assign s_axis_tready = (count_reg != CNT_W'(QueueDepth));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign req_valid     = (count_reg != '0);
    assign pop           = req_valid && req_ready;
    assign req           = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QueueDepth))
        else $error("request queue count out of range");

    a_push_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (rd_ptr_reg != $past(rd_ptr_reg)) || (QueueDepth == 1))
        else $error("read pointer did not advance on pop");

endmodule

[rtl/core/usemi_back.sv]
module usemi_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  usemi_pkg::req_t                 req,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [usemi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import usemi_pkg::*;

    logic                       busy_reg, busy_next;
    logic [COORD_W-1:0]         cx_reg, cy_reg;
    logic                       color_reg;
    logic [COL_W-1:0]           col_reg, col_next;
    logic signed [ROW_W-1:0]    row_reg, row_next;
    logic signed [TERM_W-1:0]   term_reg, term_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]      out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;
    logic                       take_req, step_en, done;
    logic signed [TERM_W-1:0]   col_t, row_t;
    logic [COORD_W-1:0]         c8, r8;

    assign req_ready = !busy_reg;
    assign take_req  = req_valid && req_ready;
    assign step_en   = busy_reg && (!out_valid_reg || m_axis_tready);

    // one midpoint step from the current offsets
    always_comb
    begin
        col_t = signed'(TERM_W'(col_reg));
        row_t = TERM_W'(row_reg);
        c8    = COORD_W'(col_reg);
        r8    = row_reg[COORD_W-1:0];
        if (term_reg < 0)
        begin
            term_next = term_reg + STEP_INC_INSIDE + (col_t <<< 1);
            row_next  = row_reg;
        end
        else
        begin
            term_next = term_reg + STEP_INC_OUTSIDE + ((col_t - row_t) <<< 1);
            row_next  = row_reg - 1'b1;
        end
        col_next = col_reg + 1'b1;
        done     = (signed'(ROW_W'(col_next)) > row_next) || (col_next >= COL_W'(MAX_STEPS));
        out_data_next = {7'b0, color_reg,
                         cy_reg - c8, cx_reg - r8,     // west
                         cy_reg - r8, cx_reg - c8,     // upper left
                         cy_reg - r8, cx_reg + c8,     // upper right
                         cy_reg - c8, cx_reg + r8};    // east
        out_last_next = done;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (take_req)
        begin
            busy_next = 1'b1;
        end
        else if (step_en && done)
        begin
            busy_next = 1'b0;
        end
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            cx_reg    <= req.center_x;
            cy_reg    <= req.center_y;
            color_reg <= req.color;
            col_reg   <= '0;
            row_reg   <= req.row_start;
            term_reg  <= req.term_start;
        end
        else if (step_en)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            term_reg <= term_next;
        end
        if (step_en)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> (col_reg < COL_W'(MAX_STEPS)))
        else $error("step engine ran past the step limit");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && done) |=> (!busy_reg && out_last_reg && out_valid_reg))
        else $error("final step did not close the run");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !take_req)
        else $error("request taken while a run is active");

    a_row_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> (row_reg >= 0))
        else $error("row offset negative on an emitted step");

endmodule

[sim/upper_semicircle_rasterizer_tb.sv]
`timescale 1ns / 100ps

module upper_semicircle_rasterizer_tb;

    import usemi_pkg::*;

    localparam int LIMIT_CYCLES = 400000;  // far above the slowest correct run
    localparam int HOLD_CYCLES  = 300;     // long output stall so the request queue backs up
    localparam int IDLE_PCT     = 32;      // chance of an idle cycle on either side
    localparam int RANDOM_DRAWS = 270;
    localparam int DRAIN_CYCLES = 64;      // drain time after the last result
    localparam int NUM_CHECKS   = 11;      // eight coordinates, color, pad, last

    // one expected step: coordinates packed as on the output bus, east_x lowest
    typedef struct packed {
        logic [63:0] coords;
        logic        pixel_value;
        logic        last_step;
    } step_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    logic [IN_DATA_W-1:0]  draw_requests[$];   // items waiting for the driver
    step_t                 pending_steps[$];   // predicted steps not yet seen on the output

    int   accepted_draws = 0;
    int   fail_count     = 0;
    int   cycle_count    = 0;
    int   hold_left      = 0;
    bit   hold_done      = 1'b0;

    step_t      want_step;
    logic [7:0] got_field[NUM_CHECKS];
    logic [7:0] want_field[NUM_CHECKS];
    string      field_name[NUM_CHECKS] = '{"east_x", "east_y", "upper_right_x",
        "upper_right_y", "upper_left_x", "upper_left_y", "west_x", "west_y",
        "pixel_value", "pad", "last_step"};

    // stretch of requests during which neither side idles
    wire calm = (accepted_draws >= 120) && (accepted_draws < 170);

    upper_semicircle_rasterizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // pack a draw request: center_x lowest, pen_color at the top
    function automatic void queue_draw(input logic [7:0] cx, input logic [7:0] cy,
                                       input logic [6:0] rad, input logic color);
        draw_requests.push_back({color, rad, cy, cx});
    endfunction

    // midpoint circle, upper half: one expected step per iteration until col passes row,
    // cut at the step limit for radii the block cannot finish
    function automatic void plan_semicircle(input logic [IN_DATA_W-1:0] req);
        int    cx;
        int    cy;
        int    col;
        int    row;
        int    term;
        int    count;
        logic  done;
        step_t s;
        cx    = int'(req[7:0]);
        cy    = int'(req[15:8]);
        row   = int'(req[22:16]);
        col   = 0;
        term  = 1 - row;
        count = 0;
        done  = 1'b0;
        while (!done)
        begin
            // west_y, west_x, upper_left_y/x, upper_right_y/x, east_y, east_x
            s.coords = {8'(cy - col), 8'(cx - row), 8'(cy - row), 8'(cx - col),
                        8'(cy - row), 8'(cx + col), 8'(cy - col), 8'(cx + row)};
            s.pixel_value = req[23];
            if (term < 0)
            begin
                term = term + 3 + 2 * col;
            end
            else
            begin
                term = term + 5 + 2 * (col - row);
                row  = row - 1;
            end
            col   = col + 1;
            count = count + 1;
            done  = (col > row) || (count >= MAX_STEPS);
            s.last_step = done;
            pending_steps.push_back(s);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: mismatch on %s, got %0h expected %0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    // driver: a new item goes out once the last one was taken or none was up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                plan_semicircle(s_axis_tdata);
                accepted_draws <= accepted_draws + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (draw_requests.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= draw_requests.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off while the sender keeps offering
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && accepted_draws >= 40)
            begin
                hold_left     <= HOLD_CYCLES;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // monitor: every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_steps.size() == 0)
            begin
                report_mismatch("unexpected result", {7'd0, m_axis_tlast}, 8'h00);
            end
            else
            begin
                want_step = pending_steps.pop_front();
                for (int k = 0; k < 8; k++)
                begin
                    got_field[k]  = m_axis_tdata[8*k +: 8];
                    want_field[k] = want_step.coords[8*k +: 8];
                end
                got_field[8]   = {7'd0, m_axis_tdata[64]};
                want_field[8]  = {7'd0, want_step.pixel_value};
                got_field[9]   = {1'b0, m_axis_tdata[71:65]};
                want_field[9]  = 8'h00;
                got_field[10]  = {7'd0, m_axis_tlast};
                want_field[10] = {7'd0, want_step.last_step};
                for (int k = 0; k < NUM_CHECKS; k++)
                begin
                    if (got_field[k] !== want_field[k])
                    begin
                        report_mismatch(field_name[k], got_field[k], want_field[k]);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int sel;
        int total_draws;
        logic [6:0] rad;

        // zero radius, single step at the center
        queue_draw(8'd128, 8'd128, 7'd0, 1'b1);
        queue_draw(8'd0,   8'd0,   7'd0, 1'b0);
        // tiny circles, the first two at the corners where coordinates wrap
        queue_draw(8'd255, 8'd255, 7'd1, 1'b1);
        queue_draw(8'd0,   8'd0,   7'd1, 1'b0);
        queue_draw(8'd128, 8'd200, 7'd2, 1'b1);
        queue_draw(8'd200, 8'd30,  7'd3, 1'b0);
        // largest radius that still completes on its own
        queue_draw(8'd0,   8'd0,   7'd88, 1'b1);
        queue_draw(8'd255, 8'd255, 7'd88, 1'b0);
        // radius beyond the step limit, run cut short
        queue_draw(8'd100, 8'd80,  7'd89, 1'b1);
        queue_draw(8'd5,   8'd5,   7'd100, 1'b1);
        queue_draw(8'd10,  8'd250, 7'd127, 1'b0);
        queue_draw(8'd255, 8'd0,   7'd127, 1'b1);
        // alternating bit patterns in every field, then mid-size radii at other centers
        queue_draw(8'd170, 8'd85,  7'd85, 1'b0);
        queue_draw(8'd85,  8'd170, 7'd42, 1'b1);
        queue_draw(8'd128, 8'd128, 7'd64, 1'b0);
        queue_draw(8'd0,   8'd255, 7'd45, 1'b1);

        // random part: mostly legal radii, a share of small ones and of oversized ones
        repeat (RANDOM_DRAWS)
        begin
            sel = $urandom_range(99);
            if (sel < 20)
            begin
                rad = 7'($urandom_range(8));
            end
            else if (sel < 85)
            begin
                rad = 7'($urandom_range(88));
            end
            else
            begin
                rad = 7'($urandom_range(127, 89));
            end
            queue_draw(8'($urandom_range(255)), 8'($urandom_range(255)), rad,
                       1'($urandom_range(1)));
        end
        total_draws = draw_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_draws < total_draws)
        begin
            @(posedge clk);
        end
        while (pending_steps.size() != 0)
        begin
            @(posedge clk);
        end
        // stray results after the last expected one are caught by the monitor
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
